FILE: design/tita_pkg.sv
package tita_pkg;

    localparam int ID_W             = 32;
    localparam int MAX_LEVELS       = 8;
    localparam int NUM_DIV          = MAX_LEVELS - 1;
    localparam int BITS_PER_STAGE   = 2;
    localparam int STAGES_PER_LEVEL = ID_W / BITS_PER_STAGE;
    localparam int LVL_W            = 3;
    localparam int CNT_W            = 4;
    localparam int IDX_W            = 4;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_LEVEL_COUNT = 4'd0;
    localparam logic [IDX_W-1:0] REG_DIV_FIRST   = 4'd1;
    localparam logic [IDX_W-1:0] REG_DIV_LAST    = 4'd7;

    typedef logic [ID_W-1:0] word_t;

    // one item in flight: digits so far, running remainder, divider state
    typedef struct packed {
        word_t [NUM_DIV:1] dig;
        word_t             cur;
        word_t             quo;
        word_t             prem;
    } item_t;

endpackage

FILE: design/terminal_id_to_tree_address.sv
// Structure: 7 levels x 16 divider stages = 112 register stages, followed by the output
// register, which loads an item from the last stage when it takes it.
// Throughput: one item per effective level count (1..8) output beats; the divider pipeline
// takes a beat every cycle and stalls as a whole while its last item cannot be taken.
// Reset: synchronous, active low; clears valid bits, level_count to 1, divisors to 1.
module terminal_id_to_tree_address
    import tita_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  word_t            cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  word_t            s_terminal_id,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [LVL_W-1:0] m_level,
    output word_t            m_digit,
    output logic             m_last
);

    logic [CNT_W-1:0] level_count_reg;
    word_t            div_reg [1:NUM_DIV];
    logic [CNT_W-1:0] n_eff;

    logic             en;
    logic             take;
    logic             lv_valid [0:NUM_DIV];
    item_t            lv_item  [0:NUM_DIV];

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_count_reg <= CNT_W'(1);
            for (int i = 1; i <= NUM_DIV; i++) begin
                div_reg[i] <= ID_W'(1);
            end
        end else if (cfg_valid) begin
            if (cfg_index == REG_LEVEL_COUNT) begin
                level_count_reg <= cfg_data[CNT_W-1:0];
            end else if (cfg_index >= REG_DIV_FIRST && cfg_index <= REG_DIV_LAST) begin
                div_reg[cfg_index[LVL_W-1:0]] <= cfg_data;
            end
        end
    end

    // clamp the level count to 1..MAX_LEVELS
    always_comb begin
        n_eff = level_count_reg;
        if (level_count_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (level_count_reg > CNT_W'(MAX_LEVELS)) begin
            n_eff = CNT_W'(MAX_LEVELS);
        end
    end

    // advance the whole pipeline unless the tail beat cannot move on
    assign en      = !lv_valid[NUM_DIV] || take;
    assign s_ready = en;

    always_comb begin
        lv_item[0]      = '0;
        lv_item[0].cur  = s_terminal_id;
        lv_valid[0]     = s_valid;
    end

    // one divider chain per level above level zero, top level first
    for (genvar k = 0; k < NUM_DIV; k++) begin : g_level
        tita_level u_level (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .lvl       (LVL_W'(NUM_DIV - k)),
            .divisor   (div_reg[NUM_DIV-k]),
            .active    (CNT_W'(NUM_DIV - k) < n_eff),
            .in_valid  (lv_valid[k]),
            .in_item   (lv_item[k]),
            .out_valid (lv_valid[k+1]),
            .out_item  (lv_item[k+1])
        );
    end

    tita_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .n_eff    (n_eff),
        .in_valid (lv_valid[NUM_DIV]),
        .in_item  (lv_item[NUM_DIV]),
        .take     (take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_level  (m_level),
        .m_digit  (m_digit),
        .m_last   (m_last)
    );

endmodule

FILE: design/tita_div_stage.sv
module tita_div_stage
    import tita_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             first,
    input  logic             last,
    input  logic             active,
    input  logic [LVL_W-1:0] lvl,
    input  word_t            divisor,
    input  logic             in_valid,
    input  item_t            in_item,
    output logic             out_valid,
    output item_t            out_item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    // restoring division, two quotient bits per stage
    always_comb begin
        word_t         x;
        word_t         r;
        logic [ID_W:0] t;
        item_next = in_item;
        x = first ? in_item.cur : in_item.quo;
        r = first ? '0 : in_item.prem;
        t = '0;
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
            t = {r, x[ID_W-1]};
            x = {x[ID_W-2:0], 1'b0};
            if (t >= {1'b0, divisor}) begin
                t    = t - {1'b0, divisor};
                x[0] = 1'b1;
            end
            r = t[ID_W-1:0];
        end
        item_next.quo  = x;
        item_next.prem = r;
        // commit digit and remainder for a level in use
        if (last && active) begin
            item_next.dig[lvl] = x;
            item_next.cur      = r;
        end
    end

    // advance the stage on enable
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: design/tita_level.sv
module tita_level
    import tita_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [LVL_W-1:0] lvl,
    input  word_t            divisor,
    input  logic             active,
    input  logic             in_valid,
    input  item_t            in_item,
    output logic             out_valid,
    output item_t            out_item
);

    logic  v  [0:STAGES_PER_LEVEL];
    item_t it [0:STAGES_PER_LEVEL];

    assign v[0]  = in_valid;
    assign it[0] = in_item;

    // chain of divider stages for one level
    for (genvar s = 0; s < STAGES_PER_LEVEL; s++) begin : g_stage
        tita_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .first     (s == 0),
            .last      (s == STAGES_PER_LEVEL - 1),
            .active    (active),
            .lvl       (lvl),
            .divisor   (divisor),
            .in_valid  (v[s]),
            .in_item   (it[s]),
            .out_valid (v[s+1]),
            .out_item  (it[s+1])
        );
    end

    assign out_valid = v[STAGES_PER_LEVEL];
    assign out_item  = it[STAGES_PER_LEVEL];

endmodule

FILE: design/tita_ser.sv
module tita_ser
    import tita_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] n_eff,
    input  logic             in_valid,
    input  item_t            in_item,
    output logic             take,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [LVL_W-1:0] m_level,
    output word_t            m_digit,
    output logic             m_last
);

    logic             busy_reg;
    logic             busy_next;
    logic [LVL_W-1:0] lvl_reg;
    logic [LVL_W-1:0] lvl_next;
    word_t [NUM_DIV:0] dig_reg;

    logic             beat;

    assign beat = busy_reg && m_ready;
    assign take = in_valid && (!busy_reg || (beat && lvl_reg == '0));

    // step down through the levels, load the next item on the last beat or when idle
    always_comb begin
        busy_next = busy_reg;
        lvl_next  = lvl_reg;
        if (take) begin
            busy_next = 1'b1;
            lvl_next  = LVL_W'(n_eff - 1'b1);
        end else if (beat) begin
            if (lvl_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                lvl_next = lvl_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            lvl_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            lvl_reg  <= lvl_next;
        end
    end

    // hold the digits, level zero takes the final remainder
    always_ff @(posedge aclk) begin
        if (take) begin
            dig_reg <= {in_item.dig, in_item.cur};
        end
    end

    assign m_valid = busy_reg;
    assign m_level = lvl_reg;
    assign m_digit = dig_reg[lvl_reg];
    assign m_last  = (lvl_reg == '0);

endmodule

FILE: design/tita_checker.sv
module tita_checker
    import tita_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input logic [LVL_W-1:0] m_level,
    input word_t            m_digit,
    input logic             m_last
);

    // a stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digit) && $stable(m_level))
        else $error("stalled result beat changed");

    // last flag marks level zero only
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_level == '0)))
        else $error("last flag does not match level zero");

    // after a non-final beat the next level down follows at once
    a_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && (m_level == $past(m_level) - 1'b1))
        else $error("level sequence broken");

    // nothing leaves straight after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind terminal_id_to_tree_address tita_checker u_tita_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_level (m_level),
    .m_digit (m_digit),
    .m_last  (m_last)
);
